FILE: sv/bpq_pkg.sv
// Shared types and constants for the bucket priority queue.
// Used by every module of the block; depends on nothing.
package bpq_pkg;

  // Default sizes, handed down from the top level
  localparam int DEF_NUM_BUCKETS = 256;
  localparam int DEF_CAPACITY    = 1024;
  localparam int DEF_MAX_WORKERS = 16;

  // Fixed field widths
  localparam int FUNC_W    = 2;
  localparam int KEY_W     = 8;
  localparam int ID_W      = 24;
  localparam int GRP_W     = 4;
  localparam int PAY_W     = ID_W + GRP_W;
  localparam int STAT_W    = 3;
  localparam int CNT_OUT_W = 11;

  // Stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // Bucket bits examined per scan cycle
  localparam int SCAN_W = 16;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH    = 2'd0,
    FN_POP     = 2'd1,
    FN_RELEASE = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_PUSHED    = 3'd0,
    ST_POPPED    = 3'd1,
    ST_WAIT      = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_REFUSED   = 3'd4,
    ST_RELEASED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_SCAN,
    S_POP_RD,
    S_POP_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [ID_W-1:0]   id;
    logic [GRP_W-1:0]  group;
  } cmd_t;

  typedef struct packed {
    status_t              status;
    logic [KEY_W-1:0]     key;
    logic [ID_W-1:0]      id;
    logic [GRP_W-1:0]     group;
    logic [CNT_OUT_W-1:0] count;
  } res_t;

  // Bitmap operations requested by the core
  typedef struct packed {
    logic start;
    logic set;
    logic clr;
  } scan_op_t;

endpackage

FILE: sv/bucket_priority_queue.sv
// Bucket priority queue: smallest key first, oldest first within a key.
// Takes one transaction at a time. A pop walks the non-empty bitmap scan in
// 16-bucket groups from the best key to the served bucket. The bucket, link
// and payload memories each have one write port and one read port with
// registered read data. A finished result waits in an output register, and
// the next transaction is taken while it waits. Depends on bpq_pkg, bpq_core,
// bpq_scan.
module bucket_priority_queue #(
  parameter int NUM_BUCKETS = bpq_pkg::DEF_NUM_BUCKETS,
  parameter int CAPACITY    = bpq_pkg::DEF_CAPACITY,
  parameter int MAX_WORKERS = bpq_pkg::DEF_MAX_WORKERS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // priority_key [7:0], payload_id [31:8], payload_group [35:32], zero pad
  input  logic [bpq_pkg::IN_DATA_W-1:0]      in_tdata,
  // func [1:0]
  input  logic [bpq_pkg::FUNC_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_key [7:0], out_id [31:8], out_group [35:32], entry_count [46:36], zero pad
  output logic [bpq_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status [2:0]
  output logic [bpq_pkg::STAT_W-1:0]         out_tuser
);
  import bpq_pkg::*;

  cmd_t cmd;
  res_t core_res;
  res_t out_res_r;
  logic out_valid_r, out_valid_nxt;
  logic core_ready;
  logic core_done;
  logic res_take;

  // Unpack the input transaction
  assign cmd.func  = in_tuser;
  assign cmd.key   = in_tdata[KEY_W-1:0];
  assign cmd.id    = in_tdata[KEY_W+ID_W-1:KEY_W];
  assign cmd.group = in_tdata[KEY_W+PAY_W-1:KEY_W+ID_W];

  bpq_core #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .CAPACITY    (CAPACITY),
    .MAX_WORKERS (MAX_WORKERS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (core_ready),
    .cmd       (cmd),
    .res_valid (core_done),
    .res_take  (res_take),
    .res       (core_res)
  );

  assign in_tready = core_ready;

  // Load the output register when it is empty or being drained
  assign res_take = core_done && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {1'b0, out_res_r.count, out_res_r.group, out_res_r.id, out_res_r.key};

endmodule

FILE: sv/bpq_scan.sv
// Non-empty bitmap of the buckets and the upward scan for the first set bit.
// Depends on bpq_pkg.
module bpq_scan #(
  parameter int NUM_BUCKETS = bpq_pkg::DEF_NUM_BUCKETS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bpq_pkg::scan_op_t              op,
  input  logic [$clog2(NUM_BUCKETS)-1:0] idx,
  output logic                           hit,
  output logic                           found,
  output logic [$clog2(NUM_BUCKETS)-1:0] found_key
);
  import bpq_pkg::*;

  localparam int KW  = $clog2(NUM_BUCKETS);
  localparam int LG  = $clog2(SCAN_W);
  localparam int NG  = (NUM_BUCKETS + SCAN_W - 1) / SCAN_W;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int PW  = GW + LG;
  localparam int NBP = 1 << PW;

  logic [NBP-1:0]    bitmap_r, bitmap_nxt;
  logic [PW-1:0]     ptr_r, ptr_nxt;
  logic              scan_r, scan_nxt;
  logic [SCAN_W-1:0] win;
  logic [SCAN_W-1:0] hits;
  logic [LG-1:0]     enc;
  logic              any;

  // Window of the group under the pointer, bits below the pointer masked
  assign win = bitmap_r[{ptr_r[PW-1:LG], LG'(0)} +: SCAN_W];

  always_comb begin
    for (int i = 0; i < SCAN_W; i++) begin
      hits[i] = win[i] && (LG'(i) >= ptr_r[LG-1:0]);
    end
  end

  // Pick the lowest set bit of the window
  always_comb begin
    any = 1'b0;
    enc = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (hits[i]) begin
        any = 1'b1;
        enc = LG'(i);
      end
    end
  end

  assign hit       = bitmap_r[PW'(idx)];
  assign found     = scan_r && any;
  assign found_key = KW'({ptr_r[PW-1:LG], enc});

  // Update bitmap and advance the scan one group a cycle
  always_comb begin
    bitmap_nxt = bitmap_r;
    ptr_nxt    = ptr_r;
    scan_nxt   = scan_r;
    if (op.set) begin
      bitmap_nxt[PW'(idx)] = 1'b1;
    end
    if (op.clr) begin
      bitmap_nxt[PW'(idx)] = 1'b0;
    end
    if (op.start) begin
      scan_nxt = 1'b1;
      ptr_nxt  = PW'(idx);
    end else if (scan_r) begin
      if (any) begin
        scan_nxt = 1'b0;
      end else begin
        ptr_nxt = {ptr_r[PW-1:LG] + GW'(1), LG'(0)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitmap_r <= '0;
      ptr_r    <= '0;
      scan_r   <= 1'b0;
    end else begin
      bitmap_r <= bitmap_nxt;
      ptr_r    <= ptr_nxt;
      scan_r   <= scan_nxt;
    end
  end

endmodule

FILE: sv/bpq_core.sv
// Sequencer and memories of the queue: bucket head/tail, link and payload stores.
// Depends on bpq_pkg and bpq_scan.
module bpq_core #(
  parameter int NUM_BUCKETS = bpq_pkg::DEF_NUM_BUCKETS,
  parameter int CAPACITY    = bpq_pkg::DEF_CAPACITY,
  parameter int MAX_WORKERS = bpq_pkg::DEF_MAX_WORKERS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  bpq_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_take,
  output bpq_pkg::res_t res
);
  import bpq_pkg::*;

  localparam int KW = $clog2(NUM_BUCKETS);
  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int BW = $clog2(MAX_WORKERS + 1);

  // Storage
  logic [2*SW-1:0]  bkt_mem  [NUM_BUCKETS];
  logic [SW:0]      link_mem [CAPACITY];
  logic [PAY_W-1:0] pay_mem  [CAPACITY];

  // Control and counters
  state_t           state_r, state_nxt;
  logic [KW-1:0]    key_r, key_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;
  logic [SW:0]      free_head_r, free_head_nxt;
  logic [SW:0]      fresh_r, fresh_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [KW:0]      best_r, best_nxt;
  logic [BW-1:0]    busy_r, busy_nxt;

  // Result payload
  status_t          rstat_r, rstat_nxt;
  logic [KW-1:0]    rkey_r, rkey_nxt;
  logic [PAY_W-1:0] rpay_r, rpay_nxt;

  // Memory read data and ports
  logic [2*SW-1:0]  bkt_rd_r;
  logic [SW:0]      link_rd_r;
  logic [PAY_W-1:0] pay_rd_r;
  logic             bkt_re, bkt_we;
  logic [KW-1:0]    bkt_raddr, bkt_waddr;
  logic [2*SW-1:0]  bkt_wdata;
  logic             link_re, link_we;
  logic [SW-1:0]    link_raddr, link_waddr;
  logic [SW:0]      link_wdata;
  logic             pay_re, pay_we;
  logic [SW-1:0]    pay_raddr, pay_waddr;
  logic [PAY_W-1:0] pay_wdata;

  // Bitmap and scan
  scan_op_t         sop;
  logic [KW-1:0]    sidx;
  logic             shit;
  logic             sfound;
  logic [KW-1:0]    skey;

  logic             push_refuse;
  logic [SW-1:0]    head, tail, slot;

  bpq_scan #(.NUM_BUCKETS(NUM_BUCKETS)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (sop),
    .idx       (sidx),
    .hit       (shit),
    .found     (sfound),
    .found_key (skey)
  );

  assign push_refuse = (32'(cmd.key) >= NUM_BUCKETS) || (count_r == CW'(CAPACITY));
  assign head        = bkt_rd_r[2*SW-1:SW];
  assign tail        = bkt_rd_r[SW-1:0];
  assign slot        = free_head_r[SW-1:0];
  assign sidx        = (state_r == S_IDLE) ? best_r[KW-1:0] : key_r;

  assign cmd_ready   = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_DONE);
  assign res.status  = rstat_r;
  assign res.key     = KEY_W'(rkey_r);
  assign res.id      = rpay_r[ID_W-1:0];
  assign res.group   = rpay_r[PAY_W-1:ID_W];
  assign res.count   = CNT_OUT_W'(count_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.func)
            FN_PUSH: state_nxt = push_refuse ? S_DONE : S_PUSH;
            FN_POP:  state_nxt = (count_r != '0) ? S_SCAN : S_DONE;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_PUSH:   state_nxt = S_DONE;
      S_SCAN:   state_nxt = sfound ? S_POP_RD : S_SCAN;
      S_POP_RD: state_nxt = S_POP_WR;
      S_POP_WR: state_nxt = S_DONE;
      S_DONE:   state_nxt = res_take ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory ports and counters
  always_comb begin
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    free_head_nxt = free_head_r;
    fresh_nxt     = fresh_r;
    count_nxt     = count_r;
    best_nxt      = best_r;
    busy_nxt      = busy_r;
    rstat_nxt     = rstat_r;
    rkey_nxt      = rkey_r;
    rpay_nxt      = rpay_r;
    bkt_re        = 1'b0;
    bkt_raddr     = key_r;
    bkt_we        = 1'b0;
    bkt_waddr     = key_r;
    bkt_wdata     = bkt_rd_r;
    link_re       = 1'b0;
    link_raddr    = slot;
    link_we       = 1'b0;
    link_waddr    = slot;
    link_wdata    = free_head_r;
    pay_re        = 1'b0;
    pay_raddr     = head;
    pay_we        = 1'b0;
    pay_waddr     = slot;
    pay_wdata     = pay_r;
    sop           = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          key_nxt  = KW'(cmd.key);
          pay_nxt  = {cmd.group, cmd.id};
          rkey_nxt = '0;
          rpay_nxt = '0;
          case (cmd.func)
            FN_PUSH: begin
              rstat_nxt = push_refuse ? ST_REFUSED : ST_PUSHED;
              // fetch bucket pointers and the free chain successor
              bkt_re     = 1'b1;
              bkt_raddr  = KW'(cmd.key);
              link_re    = 1'b1;
              link_raddr = slot;
            end
            FN_POP: begin
              if (count_r != '0) begin
                sop.start = 1'b1;
              end
              rstat_nxt = (busy_r != '0) ? ST_WAIT : ST_EXHAUSTED;
            end
            FN_RELEASE: begin
              if (busy_r != '0) begin
                busy_nxt = busy_r - BW'(1);
              end
              rstat_nxt = ST_RELEASED;
            end
            default: rstat_nxt = ST_REFUSED;
          endcase
        end
      end
      S_PUSH: begin
        // take the free slot; an untouched slot links to the next fresh one
        if (free_head_r == fresh_r) begin
          free_head_nxt = free_head_r + (SW+1)'(1);
          fresh_nxt     = fresh_r + (SW+1)'(1);
        end else begin
          free_head_nxt = link_rd_r;
        end
        pay_we    = 1'b1;
        pay_waddr = slot;
        pay_wdata = pay_r;
        bkt_we    = 1'b1;
        bkt_waddr = key_r;
        if (shit) begin
          link_we    = 1'b1;
          link_waddr = tail;
          link_wdata = {1'b0, slot};
          bkt_wdata  = {head, slot};
        end else begin
          bkt_wdata = {slot, slot};
          sop.set   = 1'b1;
        end
        count_nxt = count_r + CW'(1);
        if ({1'b0, key_r} < best_r) begin
          best_nxt = {1'b0, key_r};
        end
      end
      S_SCAN: begin
        if (sfound) begin
          key_nxt   = skey;
          best_nxt  = {1'b0, skey};
          bkt_re    = 1'b1;
          bkt_raddr = skey;
        end
      end
      S_POP_RD: begin
        link_re    = 1'b1;
        link_raddr = head;
        pay_re     = 1'b1;
        pay_raddr  = head;
      end
      S_POP_WR: begin
        // unlink the oldest entry and push its slot on the free chain
        if (head == tail) begin
          sop.clr = 1'b1;
        end else begin
          bkt_we    = 1'b1;
          bkt_waddr = key_r;
          bkt_wdata = {link_rd_r[SW-1:0], tail};
        end
        link_we       = 1'b1;
        link_waddr    = head;
        link_wdata    = free_head_r;
        free_head_nxt = {1'b0, head};
        count_nxt     = count_r - CW'(1);
        if (busy_r < BW'(MAX_WORKERS)) begin
          busy_nxt = busy_r + BW'(1);
        end
        rstat_nxt = ST_POPPED;
        rkey_nxt  = key_r;
        rpay_nxt  = pay_rd_r;
      end
      default: ;
    endcase
  end

  // Memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    if (bkt_re) begin
      bkt_rd_r <= bkt_mem[bkt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rd_r <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= pay_wdata;
    end
    if (pay_re) begin
      pay_rd_r <= pay_mem[pay_raddr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      fresh_r     <= '0;
      count_r     <= '0;
      best_r      <= (KW+1)'(NUM_BUCKETS);
      busy_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
      count_r     <= count_nxt;
      best_r      <= best_nxt;
      busy_r      <= busy_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    pay_r   <= pay_nxt;
    rstat_r <= rstat_nxt;
    rkey_r  <= rkey_nxt;
    rpay_r  <= rpay_nxt;
  end

endmodule

FILE: sv/bpq_checker.sv
// Port-level checks of the bucket priority queue, bound to the top level.
// Depends on bpq_pkg and bucket_priority_queue.
module bpq_checker #(
  parameter int CAPACITY = bpq_pkg::DEF_CAPACITY
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bpq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [bpq_pkg::STAT_W-1:0]     out_tuser
);
  import bpq_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Drop the entry fields unless an entry was popped
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_POPPED) |-> out_tdata[KEY_W+PAY_W-1:0] == '0)
    else $error("entry fields set on a non-pop result");

  // Never report more entries than the pool holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[KEY_W+PAY_W+CNT_OUT_W-1:KEY_W+PAY_W]) <= CAPACITY)
    else $error("entry count beyond capacity");

  // Work on one transaction at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("transaction accepted while busy");

endmodule

bind bucket_priority_queue bpq_checker #(.CAPACITY(CAPACITY)) u_bpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
